[sv/tccp_pkg.sv]
// ----------------------------------------------------------------------------
// tccp_pkg
// Shared constants, codes and command/status types of the text channel
// command parser.
// ----------------------------------------------------------------------------
package tccp_pkg;

  // fixed-point and token limits
  localparam int FRAC_BITS      = 16;
  localparam int MAX_SEPARATORS = 6;
  localparam int PARAM_COUNT    = 5;

  // field and datapath widths
  localparam int BYTE_W  = 8;
  localparam int VALUE_W = 32;
  localparam int SCALE_W = 8;
  localparam int SEP_W   = $clog2(MAX_SEPARATORS + 1);
  localparam int PROD_W  = VALUE_W + SCALE_W;
  localparam int NUM_W   = PROD_W + FRAC_BITS;
  localparam int CNT_W   = $clog2(NUM_W + 1);
  localparam int CHAN_W  = 2;

  // configuration port
  localparam int ADDR_W  = 4;
  localparam int PDATA_W = 32;
  localparam logic [1:0] REG_PITCH_LIMIT = 2'd0;
  localparam logic [1:0] REG_YAW_LIMIT   = 2'd1;
  localparam logic [1:0] REG_ROLL_LIMIT  = 2'd2;
  localparam logic [SCALE_W-1:0] LIMIT_RESET = 8'd30;

  // channel slots
  localparam logic [CHAN_W-1:0] CH_LIFT  = 2'd0;
  localparam logic [CHAN_W-1:0] CH_PITCH = 2'd1;
  localparam logic [CHAN_W-1:0] CH_YAW   = 2'd2;
  localparam logic [CHAN_W-1:0] CH_ROLL  = 2'd3;

  // reply codes
  localparam logic REPLY_OK    = 1'b0;
  localparam logic REPLY_ERROR = 1'b1;

  // scale factors from the register block
  typedef struct packed {
    logic [SCALE_W-1:0] pitch;
    logic [SCALE_W-1:0] yaw;
    logic [SCALE_W-1:0] roll;
  } limits_t;

  // controller to datapath
  typedef struct packed {
    logic              take_byte;
    logic              line_end;
    logic              mul;
    logic              load;
    logic              step;
    logic              write;
    logic              finish;
    logic [CHAN_W-1:0] idx;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_newline;
    logic line_go;
    logic div_last;
  } dp_status_t;

endpackage

[sv/tccp_regs.sv]
// ----------------------------------------------------------------------------
// tccp_regs
// Configuration registers: pitch, yaw and roll limits behind an APB-style
// port with zero wait states.
// ----------------------------------------------------------------------------
module tccp_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tccp_pkg::ADDR_W-1:0]   paddr,
  input  logic [tccp_pkg::PDATA_W-1:0]  pwdata,
  output logic [tccp_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  output tccp_pkg::limits_t             limits
);

  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      limits.pitch <= tccp_pkg::LIMIT_RESET;
      limits.yaw   <= tccp_pkg::LIMIT_RESET;
      limits.roll  <= tccp_pkg::LIMIT_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        tccp_pkg::REG_PITCH_LIMIT: limits.pitch <= pwdata[tccp_pkg::SCALE_W-1:0];
        tccp_pkg::REG_YAW_LIMIT:   limits.yaw   <= pwdata[tccp_pkg::SCALE_W-1:0];
        tccp_pkg::REG_ROLL_LIMIT:  limits.roll  <= pwdata[tccp_pkg::SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      tccp_pkg::REG_PITCH_LIMIT: prdata[tccp_pkg::SCALE_W-1:0] = limits.pitch;
      tccp_pkg::REG_YAW_LIMIT:   prdata[tccp_pkg::SCALE_W-1:0] = limits.yaw;
      tccp_pkg::REG_ROLL_LIMIT:  prdata[tccp_pkg::SCALE_W-1:0] = limits.roll;
      default:                   prdata = '0;
    endcase
  end

endmodule

[sv/tccp_div.sv]
// ----------------------------------------------------------------------------
// tccp_div
// Restoring radix-2 unsigned divider, one quotient bit per step.
// ----------------------------------------------------------------------------
module tccp_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          load,
  input  logic                          step,
  input  logic [tccp_pkg::NUM_W-1:0]    numer,
  input  logic [tccp_pkg::VALUE_W-1:0]  denom,
  output logic [tccp_pkg::NUM_W-1:0]    quot,
  output logic                          last
);

  logic [tccp_pkg::NUM_W-1:0]   nq;
  logic [tccp_pkg::VALUE_W-1:0] rem;
  logic [tccp_pkg::CNT_W-1:0]   cnt;
  logic [tccp_pkg::VALUE_W:0]   rem_sh;
  logic [tccp_pkg::VALUE_W+1:0] diff;
  logic                         fits;

  // trial subtract of the shifted remainder
  assign rem_sh = {rem, nq[tccp_pkg::NUM_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, denom};
  assign fits   = !diff[tccp_pkg::VALUE_W+1];

  assign quot = nq;
  assign last = (cnt == tccp_pkg::CNT_W'(1));

  // step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (load) begin
      cnt <= tccp_pkg::CNT_W'(tccp_pkg::NUM_W);
    end else if (step && cnt != '0) begin
      cnt <= cnt - tccp_pkg::CNT_W'(1);
    end
  end

  // numerator shifts out as quotient bits shift in
  always_ff @(posedge clk) begin
    if (load) begin
      nq  <= numer;
      rem <= '0;
    end else if (step && cnt != '0) begin
      nq  <= {nq[tccp_pkg::NUM_W-2:0], fits};
      rem <= fits ? diff[tccp_pkg::VALUE_W-1:0] : rem_sh[tccp_pkg::VALUE_W-1:0];
    end
  end

endmodule

[sv/tccp_dp.sv]
// ----------------------------------------------------------------------------
// tccp_dp
// Datapath: line lexer, number parser, parameter store, scale multiplier,
// divider and channel registers.
// ----------------------------------------------------------------------------
module tccp_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [tccp_pkg::BYTE_W-1:0]         rx_byte,
  input  tccp_pkg::limits_t                   limits,
  input  tccp_pkg::dp_cmd_t                   cmd,
  output tccp_pkg::dp_status_t                status,
  output logic                                reply_kind,
  output logic                                zero_divisor,
  output logic signed [tccp_pkg::VALUE_W-1:0] lift_value,
  output logic signed [tccp_pkg::VALUE_W-1:0] pitch_value,
  output logic signed [tccp_pkg::VALUE_W-1:0] yaw_value,
  output logic signed [tccp_pkg::VALUE_W-1:0] roll_value
);

  localparam int VW = tccp_pkg::VALUE_W;
  localparam logic [VW-1:0] MAG_CAP = {1'b1, {(VW-1){1'b0}}};
  localparam logic [VW-1:0] POS_MAX = {1'b0, {(VW-1){1'b1}}};

  localparam logic [7:0] C_NL    = 8'd10;
  localparam logic [7:0] C_TAB   = 8'd9;
  localparam logic [7:0] C_SP    = 8'd32;
  localparam logic [7:0] C_VT    = 8'd11;
  localparam logic [7:0] C_FF    = 8'd12;
  localparam logic [7:0] C_CR    = 8'd13;
  localparam logic [7:0] C_PLUS  = 8'd43;
  localparam logic [7:0] C_MINUS = 8'd45;
  localparam logic [7:0] C_ZERO  = 8'd48;
  localparam logic [7:0] C_NINE  = 8'd57;
  localparam logic [7:0] C_LOW_C = 8'd99;
  localparam logic [7:0] C_LOW_H = 8'd104;

  typedef enum logic [3:0] {
    NM_START = 4'b0001,
    NM_C     = 4'b0010,
    NM_CH    = 4'b0100,
    NM_FAIL  = 4'b1000
  } name_t;

  typedef enum logic [2:0] {
    TK_SIGN   = 3'b001,
    TK_DIGITS = 3'b010,
    TK_STOP   = 3'b100
  } phase_t;

  function automatic logic [VW-1:0] mag(input logic [VW-1:0] v);
    mag = v[VW-1] ? (~v + VW'(1)) : v;
  endfunction

  // lexer state
  name_t                         name_match, name_match_next;
  phase_t                        token_phase, token_phase_next;
  logic [tccp_pkg::SEP_W-1:0]    sep_count, sep_count_next;
  logic                          token_neg, token_neg_next;
  logic [VW-1:0]                 token_acc, token_acc_next;
  logic [VW-1:0]                 params [4];
  logic [VW-1:0]                 chans [4];

  // line and arithmetic registers
  logic [VW-1:0]                 den_mag;
  logic                          den_neg;
  logic [tccp_pkg::PROD_W-1:0]   prod;
  logic                          num_neg;

  logic                          is_sep, is_nl, is_digit, is_space_skip, is_sign;
  logic [35:0]                   acc_mul;
  logic [VW-1:0]                 acc_step;
  logic [VW-1:0]                 tok_val;
  logic [tccp_pkg::SEP_W-1:0]    sep_m1;
  logic                          line_ch5;
  logic [VW-1:0]                 cur_param;
  logic [tccp_pkg::SCALE_W-1:0]  cur_scale;
  logic [tccp_pkg::NUM_W-1:0]    quot;
  logic                          div_last;
  logic                          q_big, q_neg;
  logic [VW-1:0]                 chan_new;

  // byte classes
  assign is_nl         = (rx_byte == C_NL);
  assign is_sep        = (rx_byte == C_SP) || (rx_byte == C_TAB);
  assign is_digit      = (rx_byte >= C_ZERO) && (rx_byte <= C_NINE);
  assign is_space_skip = (rx_byte == C_CR) || (rx_byte == C_VT) || (rx_byte == C_FF);
  assign is_sign       = (rx_byte == C_PLUS) || (rx_byte == C_MINUS);

  // accumulator times ten plus digit, capped at 2^31
  assign acc_mul  = {1'b0, token_acc, 3'b000} + {3'b000, token_acc, 1'b0}
                  + {32'd0, rx_byte[3:0]};
  assign acc_step = (acc_mul >= {4'd0, MAG_CAP}) ? MAG_CAP : acc_mul[VW-1:0];

  // signed token value with saturation
  always_comb begin
    if (token_neg) begin
      tok_val = ~token_acc + VW'(1);
    end else begin
      tok_val = (token_acc >= MAG_CAP) ? POS_MAX : token_acc;
    end
  end

  assign sep_m1   = sep_count - tccp_pkg::SEP_W'(1);
  assign line_ch5 = (name_match == NM_CH)
                 && (sep_count == tccp_pkg::SEP_W'(tccp_pkg::PARAM_COUNT));

  assign status.is_newline = is_nl;
  assign status.line_go    = line_ch5 && (tok_val != '0);
  assign status.div_last   = div_last;

  // lexer next state
  always_comb begin
    name_match_next  = name_match;
    token_phase_next = token_phase;
    sep_count_next   = sep_count;
    token_neg_next   = token_neg;
    token_acc_next   = token_acc;
    if (cmd.take_byte) begin
      priority if (is_nl) begin
        name_match_next  = NM_START;
        sep_count_next   = '0;
        token_phase_next = TK_SIGN;
        token_neg_next   = 1'b0;
        token_acc_next   = '0;
      end else if (is_sep) begin
        if (sep_count < tccp_pkg::SEP_W'(tccp_pkg::MAX_SEPARATORS)) begin
          sep_count_next = sep_count + tccp_pkg::SEP_W'(1);
        end
        token_phase_next = TK_SIGN;
        token_neg_next   = 1'b0;
        token_acc_next   = '0;
      end else begin
        // command name match on the first token
        if (sep_count == '0) begin
          if (name_match == NM_START && rx_byte == C_LOW_C) begin
            name_match_next = NM_C;
          end else if (name_match == NM_C && rx_byte == C_LOW_H) begin
            name_match_next = NM_CH;
          end else begin
            name_match_next = NM_FAIL;
          end
        end
        // atol-style number scan
        unique case (token_phase)
          TK_SIGN: begin
            priority if (is_space_skip) begin
              token_phase_next = TK_SIGN;
            end else if (is_sign) begin
              token_neg_next   = (rx_byte == C_MINUS);
              token_phase_next = TK_DIGITS;
            end else if (!is_digit) begin
              token_phase_next = TK_STOP;
            end else begin
              token_phase_next = TK_DIGITS;
              token_acc_next   = acc_step;
            end
          end
          TK_DIGITS: begin
            if (is_digit) begin
              token_acc_next = acc_step;
            end else begin
              token_phase_next = TK_STOP;
            end
          end
          TK_STOP: token_phase_next = TK_STOP;
          default: token_phase_next = TK_STOP;
        endcase
      end
    end
  end

  // lexer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      name_match  <= NM_START;
      token_phase <= TK_SIGN;
      sep_count   <= '0;
      token_neg   <= 1'b0;
      token_acc   <= '0;
    end else begin
      name_match  <= name_match_next;
      token_phase <= token_phase_next;
      sep_count   <= sep_count_next;
      token_neg   <= token_neg_next;
      token_acc   <= token_acc_next;
    end
  end

  // parameter store: written at separators, cleared when a line is done
  always_ff @(posedge clk) begin
    if (rst || cmd.finish) begin
      for (int i = 0; i < 4; i++) begin
        params[i] <= '0;
      end
    end else if (cmd.take_byte && is_sep && sep_count >= tccp_pkg::SEP_W'(1)
                 && sep_count <= tccp_pkg::SEP_W'(4)) begin
      params[sep_m1[1:0]] <= tok_val;
    end
  end

  // line outcome and divisor capture
  always_ff @(posedge clk) begin
    if (rst) begin
      reply_kind   <= tccp_pkg::REPLY_ERROR;
      zero_divisor <= 1'b0;
    end else if (cmd.line_end) begin
      reply_kind   <= status.line_go ? tccp_pkg::REPLY_OK : tccp_pkg::REPLY_ERROR;
      zero_divisor <= line_ch5 && (tok_val == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.line_end) begin
      den_mag <= mag(tok_val);
      den_neg <= tok_val[VW-1];
    end
  end

  // scale multiply of the selected parameter
  assign cur_param = params[cmd.idx];

  always_comb begin
    unique case (cmd.idx)
      tccp_pkg::CH_LIFT:  cur_scale = tccp_pkg::SCALE_W'(1);
      tccp_pkg::CH_PITCH: cur_scale = limits.pitch;
      tccp_pkg::CH_YAW:   cur_scale = limits.yaw;
      tccp_pkg::CH_ROLL:  cur_scale = limits.roll;
      default:            cur_scale = limits.roll;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod    <= tccp_pkg::PROD_W'(mag(cur_param)) * tccp_pkg::PROD_W'(cur_scale);
      num_neg <= cur_param[VW-1];
    end
  end

  tccp_div u_div (
    .clk   (clk),
    .rst   (rst),
    .load  (cmd.load),
    .step  (cmd.step),
    .numer ({prod, {tccp_pkg::FRAC_BITS{1'b0}}}),
    .denom (den_mag),
    .quot  (quot),
    .last  (div_last)
  );

  // sign and saturation of the quotient
  assign q_big = |quot[tccp_pkg::NUM_W-1:VW-1];
  assign q_neg = (num_neg != den_neg) && (quot != '0);

  always_comb begin
    if (q_neg) begin
      chan_new = q_big ? MAG_CAP : (~quot[VW-1:0] + VW'(1));
    end else begin
      chan_new = q_big ? POS_MAX : quot[VW-1:0];
    end
  end

  // channel registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        chans[i] <= '0;
      end
    end else if (cmd.write) begin
      chans[cmd.idx] <= chan_new;
    end
  end

  assign lift_value  = chans[0];
  assign pitch_value = chans[1];
  assign yaw_value   = chans[2];
  assign roll_value  = chans[3];

endmodule

[sv/tccp_ctrl.sv]
// ----------------------------------------------------------------------------
// tccp_ctrl
// Controller: takes bytes, and at each newline sequences the four scaled
// divisions (error lines skip them) before presenting one reply beat.
// ----------------------------------------------------------------------------
module tccp_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  tccp_pkg::dp_status_t status,
  output tccp_pkg::dp_cmd_t    cmd
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_MUL   = 6'b000010,
    S_LOAD  = 6'b000100,
    S_DIV   = 6'b001000,
    S_WRITE = 6'b010000,
    S_REPLY = 6'b100000
  } state_t;

  state_t                        state, state_next;
  logic [tccp_pkg::CHAN_W-1:0]   idx, idx_next;
  logic                          accept;

  // a newline waits until the previous reply beat is gone
  assign in_stall = (state != S_IDLE) || (out_valid && status.is_newline);
  assign accept   = in_valid && !in_stall;

  // next state
  always_comb begin
    state_next = state;
    idx_next   = idx;
    unique case (state)
      S_IDLE: begin
        if (accept && status.is_newline) begin
          idx_next   = tccp_pkg::CH_LIFT;
          state_next = status.line_go ? S_MUL : S_REPLY;
        end
      end
      S_MUL:  state_next = S_LOAD;
      S_LOAD: state_next = S_DIV;
      S_DIV: begin
        if (status.div_last) begin
          state_next = S_WRITE;
        end
      end
      S_WRITE: begin
        if (idx == tccp_pkg::CH_ROLL) begin
          state_next = S_REPLY;
        end else begin
          idx_next   = idx + tccp_pkg::CHAN_W'(1);
          state_next = S_MUL;
        end
      end
      S_REPLY: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

  // reply beat holds until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_REPLY) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // datapath commands
  assign cmd.take_byte = accept;
  assign cmd.line_end  = accept && status.is_newline;
  assign cmd.mul       = (state == S_MUL);
  assign cmd.load      = (state == S_LOAD);
  assign cmd.step      = (state == S_DIV);
  assign cmd.write     = (state == S_WRITE);
  assign cmd.finish    = (state == S_REPLY);
  assign cmd.idx       = idx;

endmodule

[sv/text_channel_command_parser.sv]
// ----------------------------------------------------------------------------
// text_channel_command_parser
// Ordinary bytes are taken one per cycle while the controller is idle.
// A newline gives one reply beat: directly for an error line, else after
// four scaled divisions (multiply, load, bit-serial divide, write each).
// Synchronous active-high reset: limits to 30, channels and line state to 0.
// ----------------------------------------------------------------------------
module text_channel_command_parser (
  input  logic                                clk,
  input  logic                                rst,
  // configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [tccp_pkg::ADDR_W-1:0]         paddr,
  input  logic [tccp_pkg::PDATA_W-1:0]        pwdata,
  output logic [tccp_pkg::PDATA_W-1:0]        prdata,
  output logic                                pready,
  // byte input
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [tccp_pkg::BYTE_W-1:0]         rx_byte,
  // reply output
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                reply_kind,
  output logic                                zero_divisor,
  output logic signed [tccp_pkg::VALUE_W-1:0] lift_value,
  output logic signed [tccp_pkg::VALUE_W-1:0] pitch_value,
  output logic signed [tccp_pkg::VALUE_W-1:0] yaw_value,
  output logic signed [tccp_pkg::VALUE_W-1:0] roll_value
);

  tccp_pkg::limits_t    limits;
  tccp_pkg::dp_cmd_t    cmd;
  tccp_pkg::dp_status_t status;

  tccp_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .limits  (limits)
  );

  tccp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  tccp_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .rx_byte      (rx_byte),
    .limits       (limits),
    .cmd          (cmd),
    .status       (status),
    .reply_kind   (reply_kind),
    .zero_divisor (zero_divisor),
    .lift_value   (lift_value),
    .pitch_value  (pitch_value),
    .yaw_value    (yaw_value),
    .roll_value   (roll_value)
  );

  // an error line is answered through the reply state, without divisions
  a_error_reply: assert property (@(posedge clk) disable iff (rst)
    cmd.line_end && !status.line_go |=> ##1 out_valid)
    else $error("error reply not presented after newline");

  // channels only move on a divider write-back
  a_chan_write: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && !$stable({lift_value, pitch_value, yaw_value, roll_value})
    |-> $past(cmd.write))
    else $error("channel changed outside write-back");

  // a reply beat appears only at the end of a line
  a_reply_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.finish))
    else $error("reply beat without finished line");

  // a zero divisor is always an error reply
  a_zdiv_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid && zero_divisor |-> reply_kind == tccp_pkg::REPLY_ERROR)
    else $error("zero divisor reported as success");

endmodule
